@@ rtl/core/kss_pkg.sv @@
// Shared widths and sequencer step codes of the k-smallest select unit.
`default_nettype none

package kss_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KW    = 7;
  localparam int unsigned StepW = 3;

  localparam logic [StepW-1:0] STEP_M1    = 3'd0;
  localparam logic [StepW-1:0] STEP_M2    = 3'd1;
  localparam logic [StepW-1:0] STEP_M3    = 3'd2;
  localparam logic [StepW-1:0] STEP_M4    = 3'd3;
  localparam logic [StepW-1:0] STEP_SCAN  = 3'd4;
  localparam logic [StepW-1:0] STEP_FINAL = 3'd5;

endpackage

`default_nettype wire

@@ rtl/core/k_smallest_select_unit.sv @@
// Top level of the k-smallest select unit: element store, quickselect sequencer, result register.
//
// Channel   Direction  Payload                                Handshake
// s_axis    in         tdata = value, tlast = last            s_axis_tvalid / s_axis_tready
// m_axis    out        tdata = result_value, tuser = status,  m_axis_tvalid / m_axis_tready
//                      tlast = final_res
// cfg       in         cfg_data_i = k_count                   cfg_valid_i / cfg_ready_o
//
// Loading accepts one word per cycle; the store has one write port and two read ports.
// Each quickselect pass picks a median-of-three pivot, then scans the segment element by element,
// using the single compare-and-swap unit working on the store.
// Each result word is read in ST_ORD, then registered in ST_OWR once the output side is free.
// Input is accepted only while loading; the result register frees the output side from it.
// Reset clears the control state; the element store holds no reset value.
`default_nettype none

module k_smallest_select_unit
  import kss_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [DataW-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic             s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [DataW-1:0]      m_axis_tdata,   // [31:0] result_value
  output logic                  m_axis_tuser,   // [0] status
  output logic                  m_axis_tlast,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [KW-1:0]    cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_W2   = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;
  localparam logic [2:0] ST_ORD  = 3'd5;
  localparam logic [2:0] ST_OWR  = 3'd6;

  function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] lo, input logic [AW-1:0] hi);
    logic [AW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[AW:1];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [AW-1:0]    a_q, a_d, b_q, b_d;
  logic [AW-1:0]    lo_q, lo_d, hi_q, hi_d, tgt_q, tgt_d, bnd_q, bnd_d;
  logic [CW-1:0]    count_q, count_d;
  logic [KW-1:0]    k_q, k_d;
  logic [DataW-1:0] pivot_q, pivot_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic             out_user_q, out_user_d, out_last_q, out_last_d;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_a_q, rd_b_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [DataW-1:0] mem_wd;

  logic             s_acc, out_free, swap, adv, not_full;
  logic [CW-1:0]    cnt_new;
  logic [AW:0]      scan_nx;
  logic [AW-1:0]    bnd_nx, nlo, nhi;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign not_full = (count_q < CW'(DEPTH));
  assign cnt_new  = count_q + CW'(not_full);

  always_comb begin
    unique case (step_q)
      STEP_M1, STEP_M2, STEP_M3: swap = ($signed(rd_b_q) < $signed(rd_a_q));
      STEP_SCAN:                 swap = !($signed(pivot_q) < $signed(rd_b_q));
      default:                   swap = 1'b1;
    endcase
  end

  assign adv     = ((state_q == ST_CMP) && !swap) || (state_q == ST_W2);
  assign scan_nx = {1'b0, b_q} + {{AW{1'b0}}, 1'b1};
  assign bnd_nx  = bnd_q + AW'(state_q == ST_W2);

  always_comb begin
    nlo = lo_q;
    nhi = hi_q;
    if (bnd_q > tgt_q) begin
      nhi = bnd_q - AW'(1);
    end else begin
      nlo = bnd_q + AW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    a_d         = a_q;
    b_d         = b_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tgt_d       = tgt_q;
    bnd_d       = bnd_q;
    count_d     = count_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wa      = a_q;
    mem_wd      = rd_b_q;

    if (cfg_valid_i) begin
      k_d = cfg_data_i;
    end

    unique case (state_q)
      ST_LOAD: begin
        mem_wa = count_q[AW-1:0];
        mem_wd = s_axis_tdata;
        if (s_acc) begin
          mem_we  = not_full;
          count_d = cnt_new;
          if (s_axis_tlast) begin
            count_d = '0;
            if ((k_q == '0) || (k_q > KW'(cnt_new))) begin
              state_d = ST_ERR;
            end else begin
              lo_d    = '0;
              hi_d    = AW'(cnt_new - CW'(1));
              tgt_d   = AW'(k_q - KW'(1));
              a_d     = '0;
              b_d     = mid_of('0, AW'(cnt_new - CW'(1)));
              step_d  = STEP_M1;
              state_d = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (swap) begin
          mem_we  = 1'b1;
          mem_wa  = a_q;
          mem_wd  = rd_b_q;
          state_d = ST_W2;
        end
      end
      ST_W2: begin
        mem_we = 1'b1;
        mem_wa = b_q;
        mem_wd = rd_a_q;
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_user_d  = 1'b1;
          out_last_d  = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      ST_ORD: begin
        state_d = ST_OWR;
      end
      ST_OWR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_a_q;
          out_user_d  = 1'b0;
          out_last_d  = (a_q == tgt_q);
          a_d         = a_q + AW'(1);
          state_d     = (a_q == tgt_q) ? ST_LOAD : ST_ORD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (adv) begin
      state_d = ST_RD;
      unique case (step_q)
        STEP_M1: begin
          a_d    = lo_q;
          b_d    = hi_q;
          step_d = STEP_M2;
        end
        STEP_M2: begin
          a_d    = mid_of(lo_q, hi_q);
          b_d    = hi_q;
          step_d = STEP_M3;
        end
        STEP_M3: begin
          step_d = STEP_M4;
        end
        STEP_M4: begin
          pivot_d = rd_a_q;
          bnd_d   = lo_q;
          a_d     = lo_q;
          if (lo_q < hi_q) begin
            b_d    = lo_q;
            step_d = STEP_SCAN;
          end else begin
            b_d    = hi_q;
            step_d = STEP_FINAL;
          end
        end
        STEP_SCAN: begin
          bnd_d = bnd_nx;
          a_d   = bnd_nx;
          if (scan_nx < {1'b0, hi_q}) begin
            b_d = scan_nx[AW-1:0];
          end else begin
            b_d    = hi_q;
            step_d = STEP_FINAL;
          end
        end
        default: begin
          if (bnd_q == tgt_q) begin
            a_d     = '0;
            state_d = ST_ORD;
          end else begin
            lo_d   = nlo;
            hi_d   = nhi;
            a_d    = nlo;
            b_d    = mid_of(nlo, nhi);
            step_d = STEP_M1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem_q[a_q];
    rd_b_q <= mem_q[b_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      step_q      <= STEP_M1;
      a_q         <= '0;
      b_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      tgt_q       <= '0;
      bnd_q       <= '0;
      count_q     <= '0;
      k_q         <= KW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      a_q         <= a_d;
      b_q         <= b_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      tgt_q       <= tgt_d;
      bnd_q       <= bnd_d;
      count_q     <= count_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pivot_q    <= pivot_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (count_q == '0))
    else $error("Element count is not cleared outside loading.");

  a_target_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RD) || (state_q == ST_CMP) || (state_q == ST_W2))
      |-> ((lo_q <= tgt_q) && (tgt_q <= hi_q)))
    else $error("Target position left the active segment.");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RD) && (step_q == STEP_SCAN)) |-> ((bnd_q <= b_q) && (b_q < hi_q)))
    else $error("Partition scan is out of bounds.");

  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("Error word is not flagged as final.");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the k-smallest select unit: directed and random sets against a predictor.
module tb_top;
  import kss_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_WORDS = 170;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             status;
    logic             final_res;
  } pick_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;   // [31:0] value
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;   // [31:0] result_value
  logic             m_axis_tuser;   // [0] status
  logic             m_axis_tlast;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [KW-1:0]    cfg_data_i;

  logic signed [DataW-1:0] mirror_mem [DEPTH];
  int unsigned             mirror_count;
  logic [KW-1:0]           mirror_k;
  pick_t                   smallest_q [$];
  logic [DataW-1:0]        set_buf [$];

  int err_count;
  int words_in;
  int sets_done;
  int range_errors;
  int dropped_words;
  int results_checked;
  int hold_left;
  bit gaps_on;

  k_smallest_select_unit #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void swap_entries(int a, int b);
    logic signed [DataW-1:0] t;
    t = mirror_mem[a];
    mirror_mem[a] = mirror_mem[b];
    mirror_mem[b] = t;
  endfunction

  // The median of first, middle and last ends up at the top of the segment.
  function automatic void median_to_top(int lo, int hi);
    int mid;
    mid = (lo + hi) / 2;
    if (mirror_mem[mid] < mirror_mem[lo]) swap_entries(lo, mid);
    if (mirror_mem[hi] < mirror_mem[lo]) swap_entries(lo, hi);
    if (mirror_mem[hi] < mirror_mem[mid]) swap_entries(mid, hi);
    swap_entries(mid, hi);
  endfunction

  function automatic int partition_segment(int lo, int hi);
    logic signed [DataW-1:0] pivot;
    int b;
    pivot = mirror_mem[hi];
    b = lo;
    for (int i = lo; i < hi; i++) begin
      if (!(pivot < mirror_mem[i])) begin
        swap_entries(b, i);
        b++;
      end
    end
    swap_entries(b, hi);
    return b;
  endfunction

  function automatic void predict_word(logic [DataW-1:0] v, logic is_last);
    int lo;
    int hi;
    int pos;
    int target;
    pick_t r;
    if (mirror_count < DEPTH) begin
      mirror_mem[mirror_count] = v;
      mirror_count++;
    end else begin
      dropped_words++;
    end
    if (!is_last) return;
    sets_done++;
    if (mirror_k == '0 || int'(mirror_k) > int'(mirror_count)) begin
      r.value = '0;
      r.status = 1'b1;
      r.final_res = 1'b1;
      smallest_q.push_back(r);
      range_errors++;
    end else begin
      target = int'(mirror_k) - 1;
      lo = 0;
      hi = int'(mirror_count) - 1;
      forever begin
        median_to_top(lo, hi);
        pos = partition_segment(lo, hi);
        if (pos == target) break;
        if (pos > target) hi = pos - 1;
        else lo = pos + 1;
      end
      for (int i = 0; i < int'(mirror_k); i++) begin
        r.value = mirror_mem[i];
        r.status = 1'b0;
        r.final_res = (i == target);
        smallest_q.push_back(r);
      end
    end
    mirror_count = 0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DataW-1:0] rand_value(int mode);
    logic [DataW-1:0] extremes [5];
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    case (mode)
      1: return DataW'($urandom_range(0, 15)) - DataW'(8);
      2: return extremes[$urandom_range(0, 4)];
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_set(int n);
    int mode;
    int r;
    r = $urandom_range(0, 9);
    mode = (r < 6) ? 0 : (r < 8) ? 1 : 2;
    set_buf.delete();
    for (int i = 0; i < n; i++) set_buf.push_back(rand_value(mode));
  endfunction

  function automatic void check_word();
    pick_t want;
    results_checked++;
    if (smallest_q.size() == 0) begin
      $error("unexpected result word: result_value %h status %b final_res %b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      err_count++;
      return;
    end
    want = smallest_q.pop_front();
    if (m_axis_tdata !== want.value) begin
      $error("result_value: expected %0d, actual %0d", $signed(want.value),
             $signed(m_axis_tdata));
      err_count++;
    end
    if (m_axis_tuser !== want.status) begin
      $error("status: expected %b, actual %b", want.status, m_axis_tuser);
      err_count++;
    end
    if (m_axis_tlast !== want.final_res) begin
      $error("final_res: expected %b, actual %b", want.final_res, m_axis_tlast);
      err_count++;
    end
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input logic [DataW-1:0] v, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(v, is_last);
    words_in++;
  endtask

  task automatic send_set();
    for (int i = 0; i < set_buf.size(); i++) send_word(set_buf[i], i == set_buf.size() - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (smallest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [KW-1:0] k);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mirror_k = k;
  endtask

  // Value extremes, k at its reset value, k of zero, k above the count,
  // duplicates and k equal to the count.
  task automatic test_directed();
    set_buf = '{32'd123};
    send_set();
    write_k(7'd3);
    set_buf = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    send_set();
    write_k(7'd0);
    set_buf = '{32'd5};
    send_set();
    write_k(7'd6);
    set_buf = '{32'd10, -32'sd10, 32'd20, -32'sd20, 32'd0};
    send_set();
    write_k(7'd2);
    set_buf = '{32'd42, 32'd42, 32'd42, 32'd42};
    send_set();
    write_k(7'd5);
    set_buf = '{-32'sd3, 32'd9, -32'sd7, 32'd1, 32'd0};
    send_set();
  endtask

  task automatic test_store_overflow();
    write_k(7'd64);
    build_set(70);
    send_set();
    write_k(7'd65);
    build_set(66);
    send_set();
    write_k(7'd127);
    build_set(3);
    send_set();
    write_k(7'd32);
    set_buf.delete();
    for (int i = 63; i >= 0; i--) set_buf.push_back(DataW'(i));
    send_set();
  endtask

  task automatic test_random_sets();
    int stop_at;
    int r;
    int n;
    stop_at = words_in + RANDOM_WORDS;
    while (words_in < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) write_k(KW'($urandom_range(1, 8)));
        else if (r < 80) write_k(KW'($urandom_range(9, 32)));
        else if (r < 88) write_k(KW'($urandom_range(33, 64)));
        else if (r < 94) write_k(7'd0);
        else write_k(KW'($urandom_range(65, 127)));
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = int'(mirror_k) + $urandom_range(0, 12);
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
      end else if (r < 95) begin
        n = $urandom_range(1, DEPTH);
      end else begin
        n = $urandom_range(DEPTH + 1, DEPTH + 8);
      end
      build_set(n);
      send_set();
    end
  endtask

  // The output side stops for a long stretch while new sets keep coming.
  task automatic test_backpressure();
    write_k(7'd8);
    gaps_on = 1'b0;
    hold_left = 400;
    repeat (4) begin
      build_set(12);
      send_set();
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_no_idle();
    write_k(7'd4);
    gaps_on = 1'b0;
    repeat (5) begin
      build_set($urandom_range(4, 20));
      send_set();
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    mirror_count = 0;
    mirror_k = KW'(1);
    err_count = 0;
    words_in = 0;
    sets_done = 0;
    range_errors = 0;
    dropped_words = 0;
    results_checked = 0;
    hold_left = 0;
    gaps_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_store_overflow();
    test_backpressure();
    test_no_idle();
    test_random_sets();
    wait_idle();

    $display("Run covered %0d data sets, %0d rejected for k out of range, %0d words dropped.",
             sets_done, range_errors, dropped_words);
    $display("Sent %0d words and checked %0d result words.", words_in, results_checked);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ k_smallest_select_unit.f @@
rtl/core/kss_pkg.sv
rtl/core/k_smallest_select_unit.sv
tb/tb_top.sv
